// ===== rtl/tcpid_pkg.sv =====
// Package for the two-channel PID current loop core.
// Holds widths, register codes, reset values and the request structs.
// No dependencies; used by the core and the checker under rtl, and by the testbench.
package tcpid_pkg;

  // Number of current loops that share the state memory
  localparam int CHANNELS = 2;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int MEAS_W  = 12;
  localparam int SP_W    = 13;
  localparam int ERR_W   = 14;
  localparam int GAIN_W  = 16;
  localparam int OUT_W   = 16;
  localparam int ACC_W   = 48;
  localparam int STATE_W = ERR_W + ACC_W;

  // Products and sums of the datapath
  localparam int PK_W   = GAIN_W + ERR_W;       // Kp * e
  localparam int PE_W   = GAIN_W + ERR_W + 1;   // Ki * (e + e1), Kd * (e - e1)
  localparam int PKD_W  = 32;                   // 2*Kp*e + 2*Kd*(e - e1)
  localparam int SUM_W  = ACC_W + 1;
  localparam int FRAC_W = 13;
  localparam int Y_W    = SUM_W - FRAC_W;

  // Stages from the accepting edge up to and including the output register
  localparam int PIPE_DEPTH = 5;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_OUT_UPPER  = 3'd3,
    REG_OUT_LOWER  = 3'd4,
    REG_TARGET_CH0 = 3'd5,
    REG_TARGET_CH1 = 3'd6
  } reg_idx_e;

  localparam logic signed [GAIN_W-1:0] RST_GAIN_PROP  = 16'sd410;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_INTEG = 16'sd0;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_DERIV = 16'sd0;
  localparam logic signed [OUT_W-1:0]  RST_OUT_UPPER  = 16'sd500;
  localparam logic signed [OUT_W-1:0]  RST_OUT_LOWER  = -16'sd500;
  localparam logic signed [SP_W-1:0]   RST_TARGET     = -13'sd200;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic              chan;
    logic [MEAS_W-1:0] measured;
  } in_item_t;

  typedef struct packed {
    logic                    chan_out;
    logic signed [OUT_W-1:0] drive;
    logic                    clamped;
  } out_item_t;

endpackage

// ===== rtl/tcpid_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during a write to the same entry returns the old contents.
// No dependencies.
module tcpid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/two_channel_pid_current_loop_core.sv =====
// Channel   | Signals                                   | Request moves when
// ----------+-------------------------------------------+--------------------------------
// in        | in_valid_i, in_stall_o, in_data_i         | in_valid_i high, in_stall_o low
// out       | out_valid_o, out_stall_i, out_data_o      | out_valid_o high, out_stall_i low
// config    | psel, penable, pwrite, paddr, pwdata, ... | psel, penable, pwrite, pready high
//
// Throughput is one request per cycle while out is not stalled; a result passes stage
// registers 1 to 4 and then the output register. The rate is set by the per-channel
// integral loop: state memory read, forwarding mux and saturating add each cycle.
// Reset clears the per-entry valid bits of the state memory, so no clearing pass
// is needed. Stages with a free slot behind them keep filling while out is stalled.
//
// Top level of the two-channel PID current loop with trapezoidal integral.
// Depends on tcpid_pkg and tcpid_ram.
module two_channel_pid_current_loop_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tcpid_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tcpid_pkg::out_item_t              out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcpid_pkg::ADDR_W-1:0]      paddr,
  input  logic [tcpid_pkg::DATA_W-1:0]      pwdata,
  output logic [tcpid_pkg::DATA_W-1:0]      prdata,
  output logic                              pready
);

  // Configuration registers
  logic signed [tcpid_pkg::GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic signed [tcpid_pkg::OUT_W-1:0]  out_upper_q, out_lower_q;
  logic signed [tcpid_pkg::SP_W-1:0]   target_ch0_q, target_ch1_q;

  logic                 cfg_we;
  tcpid_pkg::reg_idx_e  cfg_idx;

  // Handshake and stage occupancy
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic in_acc;

  // Stage 1: error formed, state read from memory
  logic                               chan1_q;
  logic [tcpid_pkg::CH_AW-1:0]        idx1_q;
  logic signed [tcpid_pkg::ERR_W-1:0] err1_q;

  // Stage 2: products and old integral
  logic                               chan2_q;
  logic [tcpid_pkg::CH_AW-1:0]        idx2_q;
  logic signed [tcpid_pkg::ERR_W-1:0] err2_q;
  logic signed [tcpid_pkg::ACC_W-1:0] acc2_q;
  logic signed [tcpid_pkg::PK_W-1:0]  pk2_q;
  logic signed [tcpid_pkg::PE_W-1:0]  pi2_q, pd2_q;

  // Stage 3: new integral and the other two terms
  logic                               chan3_q;
  logic signed [tcpid_pkg::ACC_W-1:0] acc3_q;
  logic signed [tcpid_pkg::PKD_W-1:0] pkd3_q;

  // Stage 4: full sum in Q.13
  logic                               chan4_q;
  logic signed [tcpid_pkg::SUM_W-1:0] sum4_q;

  tcpid_pkg::out_item_t out_data_q, out_data_d;

  // Last state write, for a read that met the write at the same edge
  logic                               wb_valid_q;
  logic [tcpid_pkg::CH_AW-1:0]        wb_idx_q;
  logic signed [tcpid_pkg::ERR_W-1:0] wb_err_q;
  logic signed [tcpid_pkg::ACC_W-1:0] wb_acc_q;

  // Memory entries written since reset; an unwritten entry reads as zero
  logic [tcpid_pkg::CHANNELS-1:0] vld_q;

  logic [tcpid_pkg::CH_AW-1:0]        in_idx;
  logic signed [tcpid_pkg::SP_W-1:0]  in_sp;
  logic signed [tcpid_pkg::ERR_W-1:0] in_err;

  logic                                ram_we;
  logic [tcpid_pkg::STATE_W-1:0]       ram_wdata, ram_rdata;

  logic signed [tcpid_pkg::ERR_W-1:0]  prev_err;
  logic signed [tcpid_pkg::ACC_W-1:0]  prev_acc;
  logic signed [tcpid_pkg::ERR_W:0]    err_sum, err_diff;
  logic signed [tcpid_pkg::PK_W-1:0]   pk;
  logic signed [tcpid_pkg::PE_W-1:0]   pi, pd;

  logic signed [tcpid_pkg::ACC_W:0]    acc_sum;
  logic signed [tcpid_pkg::ACC_W-1:0]  acc_new;
  logic signed [tcpid_pkg::PKD_W-1:0]  pkd;
  logic signed [tcpid_pkg::SUM_W-1:0]  sum3, sum_biased;
  logic signed [tcpid_pkg::Y_W-1:0]    y;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = tcpid_pkg::reg_idx_e'(paddr[tcpid_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= tcpid_pkg::RST_GAIN_PROP;
      gain_integ_q <= tcpid_pkg::RST_GAIN_INTEG;
      gain_deriv_q <= tcpid_pkg::RST_GAIN_DERIV;
      out_upper_q  <= tcpid_pkg::RST_OUT_UPPER;
      out_lower_q  <= tcpid_pkg::RST_OUT_LOWER;
      target_ch0_q <= tcpid_pkg::RST_TARGET;
      target_ch1_q <= tcpid_pkg::RST_TARGET;
    end else if (cfg_we) begin
      case (cfg_idx)
        tcpid_pkg::REG_GAIN_PROP:  gain_prop_q  <= $signed(pwdata[tcpid_pkg::GAIN_W-1:0]);
        tcpid_pkg::REG_GAIN_INTEG: gain_integ_q <= $signed(pwdata[tcpid_pkg::GAIN_W-1:0]);
        tcpid_pkg::REG_GAIN_DERIV: gain_deriv_q <= $signed(pwdata[tcpid_pkg::GAIN_W-1:0]);
        tcpid_pkg::REG_OUT_UPPER:  out_upper_q  <= $signed(pwdata[tcpid_pkg::OUT_W-1:0]);
        tcpid_pkg::REG_OUT_LOWER:  out_lower_q  <= $signed(pwdata[tcpid_pkg::OUT_W-1:0]);
        tcpid_pkg::REG_TARGET_CH0: target_ch0_q <= $signed(pwdata[tcpid_pkg::SP_W-1:0]);
        tcpid_pkg::REG_TARGET_CH1: target_ch1_q <= $signed(pwdata[tcpid_pkg::SP_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tcpid_pkg::REG_GAIN_PROP:  prdata = tcpid_pkg::DATA_W'(gain_prop_q);
      tcpid_pkg::REG_GAIN_INTEG: prdata = tcpid_pkg::DATA_W'(gain_integ_q);
      tcpid_pkg::REG_GAIN_DERIV: prdata = tcpid_pkg::DATA_W'(gain_deriv_q);
      tcpid_pkg::REG_OUT_UPPER:  prdata = tcpid_pkg::DATA_W'(out_upper_q);
      tcpid_pkg::REG_OUT_LOWER:  prdata = tcpid_pkg::DATA_W'(out_lower_q);
      tcpid_pkg::REG_TARGET_CH0: prdata = tcpid_pkg::DATA_W'(target_ch0_q);
      tcpid_pkg::REG_TARGET_CH1: prdata = tcpid_pkg::DATA_W'(target_ch1_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // A stage moves when it is empty or the stage after it moves.
  assign rdy_out = !out_valid_q || !out_stall_i;
  assign rdy4    = !v4_q || rdy_out;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign in_acc      = in_valid_i && rdy1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q        <= in_acc;
      if (rdy2)    v2_q        <= v1_q;
      if (rdy3)    v3_q        <= v2_q;
      if (rdy4)    v4_q        <= v3_q;
      if (rdy_out) out_valid_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------- stage 0
  assign in_idx = (tcpid_pkg::CHANNELS > 1) ? tcpid_pkg::CH_AW'(in_data_i.chan) : '0;
  assign in_sp  = in_data_i.chan ? target_ch1_q : target_ch0_q;
  assign in_err = tcpid_pkg::ERR_W'(in_sp) - $signed({2'b00, in_data_i.measured});

  tcpid_ram #(
    .WIDTH (tcpid_pkg::STATE_W),
    .DEPTH (tcpid_pkg::CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx2_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- stage 1
  // Take the state from the request ahead, then the last write, then memory; an unwritten entry gives zero.
  always_comb begin
    if (v2_q && (idx2_q == idx1_q)) begin
      prev_err = err2_q;
      prev_acc = acc_new;
    end else if (wb_valid_q && (wb_idx_q == idx1_q)) begin
      prev_err = wb_err_q;
      prev_acc = wb_acc_q;
    end else if (vld_q[idx1_q]) begin
      prev_err = $signed(ram_rdata[tcpid_pkg::STATE_W-1:tcpid_pkg::ACC_W]);
      prev_acc = $signed(ram_rdata[tcpid_pkg::ACC_W-1:0]);
    end else begin
      prev_err = '0;
      prev_acc = '0;
    end
  end

  assign err_sum  = (tcpid_pkg::ERR_W+1)'(err1_q) + (tcpid_pkg::ERR_W+1)'(prev_err);
  assign err_diff = (tcpid_pkg::ERR_W+1)'(err1_q) - (tcpid_pkg::ERR_W+1)'(prev_err);
  assign pk = tcpid_pkg::PK_W'(gain_prop_q) * tcpid_pkg::PK_W'(err1_q);
  assign pi = tcpid_pkg::PE_W'(gain_integ_q) * tcpid_pkg::PE_W'(err_sum);
  assign pd = tcpid_pkg::PE_W'(gain_deriv_q) * tcpid_pkg::PE_W'(err_diff);

  // ---------------------------------------------------------------- stage 2
  // Ki*(e+e1) in Q.13 is the trapezoid step; saturate to the integral width.
  assign acc_sum = (tcpid_pkg::ACC_W+1)'(acc2_q) + (tcpid_pkg::ACC_W+1)'(pi2_q);

  always_comb begin
    if (acc_sum[tcpid_pkg::ACC_W] != acc_sum[tcpid_pkg::ACC_W-1]) begin
      acc_new = acc_sum[tcpid_pkg::ACC_W] ? tcpid_pkg::ACC_MIN : tcpid_pkg::ACC_MAX;
    end else begin
      acc_new = acc_sum[tcpid_pkg::ACC_W-1:0];
    end
  end

  assign pkd = (tcpid_pkg::PKD_W'(pk2_q) <<< 1) + (tcpid_pkg::PKD_W'(pd2_q) <<< 1);

  assign ram_we    = v2_q && rdy3;
  assign ram_wdata = {err2_q, acc_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
      vld_q      <= '0;
    end else if (ram_we) begin
      wb_valid_q     <= 1'b1;
      vld_q[idx2_q]  <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stage 3/4
  assign sum3 = tcpid_pkg::SUM_W'(acc3_q) + tcpid_pkg::SUM_W'(pkd3_q);

  // Divide by 2^13 toward zero: bias negative sums before the shift.
  assign sum_biased = sum4_q + (sum4_q[tcpid_pkg::SUM_W-1] ?
                      tcpid_pkg::SUM_W'((1 << tcpid_pkg::FRAC_W) - 1) : '0);
  assign y = $signed(sum_biased[tcpid_pkg::SUM_W-1:tcpid_pkg::FRAC_W]);

  always_comb begin
    out_data_d.chan_out = chan4_q;
    if (y < tcpid_pkg::Y_W'(out_lower_q)) begin
      out_data_d.drive   = out_lower_q;
      out_data_d.clamped = 1'b1;
    end else if (y > tcpid_pkg::Y_W'(out_upper_q)) begin
      out_data_d.drive   = out_upper_q;
      out_data_d.clamped = 1'b1;
    end else begin
      out_data_d.drive   = y[tcpid_pkg::OUT_W-1:0];
      out_data_d.clamped = 1'b0;
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_acc) begin
      chan1_q <= in_data_i.chan;
      idx1_q  <= in_idx;
      err1_q  <= in_err;
    end
    if (rdy2) begin
      chan2_q <= chan1_q;
      idx2_q  <= idx1_q;
      err2_q  <= err1_q;
      acc2_q  <= prev_acc;
      pk2_q   <= pk;
      pi2_q   <= pi;
      pd2_q   <= pd;
    end
    if (rdy3) begin
      chan3_q <= chan2_q;
      acc3_q  <= acc_new;
      pkd3_q  <= pkd;
    end
    if (rdy4) begin
      chan4_q <= chan3_q;
      sum4_q  <= sum3;
    end
    if (rdy_out) begin
      out_data_q <= out_data_d;
    end
    if (ram_we) begin
      wb_idx_q <= idx2_q;
      wb_err_q <= err2_q;
      wb_acc_q <= acc_new;
    end
  end

endmodule

// ===== rtl/tcpid_checker.sv =====
// Port-level checker for the two-channel PID current loop core, with its bind.
// Tracks requests in flight against the pipeline capacity.
// Depends on tcpid_pkg.
module tcpid_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input tcpid_pkg::out_item_t out_data_o
);

  localparam int CNT_W = $clog2(tcpid_pkg::PIPE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Every result must belong to an accepted request.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != '0)
    else $error("result without an accepted request");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(tcpid_pkg::PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

endmodule

bind two_channel_pid_current_loop_core tcpid_checker u_tcpid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/tb_two_channel_pid_current_loop_core.sv =====
// Self-checking testbench for two_channel_pid_current_loop_core.
// Drives current samples and APB register writes, predicts every drive value
// in step with the core, and checks results in order; depends on tcpid_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int MEAS_MAX     = (1 << tcpid_pkg::MEAS_W) - 1;
  localparam int UNMAPPED_IDX = 7;
  localparam int SOAK_ITEMS   = 16;

  typedef struct {
    tcpid_pkg::in_item_t item;
    int                  gap;
  } sample_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  tcpid_pkg::in_item_t            in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  tcpid_pkg::out_item_t           out_data;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [tcpid_pkg::ADDR_W-1:0]   paddr = '0;
  logic [tcpid_pkg::DATA_W-1:0]   pwdata = '0;
  logic [tcpid_pkg::DATA_W-1:0]   prdata;
  logic                           pready;

  // Register shadows and per-channel loop state of the predictor
  logic signed [tcpid_pkg::GAIN_W-1:0] kp = tcpid_pkg::RST_GAIN_PROP;
  logic signed [tcpid_pkg::GAIN_W-1:0] ki = tcpid_pkg::RST_GAIN_INTEG;
  logic signed [tcpid_pkg::GAIN_W-1:0] kd = tcpid_pkg::RST_GAIN_DERIV;
  logic signed [tcpid_pkg::OUT_W-1:0]  lim_hi = tcpid_pkg::RST_OUT_UPPER;
  logic signed [tcpid_pkg::OUT_W-1:0]  lim_lo = tcpid_pkg::RST_OUT_LOWER;
  logic signed [tcpid_pkg::SP_W-1:0]   sp_ch0 = tcpid_pkg::RST_TARGET;
  logic signed [tcpid_pkg::SP_W-1:0]   sp_ch1 = tcpid_pkg::RST_TARGET;
  logic signed [tcpid_pkg::ERR_W-1:0]  err_hist [tcpid_pkg::CHANNELS] = '{default: '0};
  logic signed [tcpid_pkg::ACC_W-1:0]  integ_acc [tcpid_pkg::CHANNELS] = '{default: '0};

  sample_req_t          sample_q[$];
  tcpid_pkg::out_item_t drive_q[$];

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int tx_wait = 0;
  int rx_wait = 0;
  int rx_hold_left = 0;
  int idle_max = 6;
  int mismatches = 0;
  int samples_taken = 0;
  int drives_seen = 0;
  int clamp_count = 0;

  two_channel_pid_current_loop_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick_end(int lo, int hi);
    return $urandom_range(0, 1) ? hi : lo;
  endfunction

  // One loop step: error, trapezoidal integral with saturation, derivative,
  // truncation toward zero and the output clamp (lower limit tested first)
  function automatic tcpid_pkg::out_item_t compute_drive(tcpid_pkg::in_item_t s);
    longint               sp, e, e1, acc, sum, y;
    int                   idx;
    tcpid_pkg::out_item_t r;
    idx = int'(s.chan) % tcpid_pkg::CHANNELS;
    sp  = s.chan ? sp_ch1 : sp_ch0;
    e   = sp - longint'(s.measured);
    e1  = err_hist[idx];
    acc = longint'(integ_acc[idx]) + longint'(ki) * (e + e1);
    if (acc > longint'(tcpid_pkg::ACC_MAX)) acc = tcpid_pkg::ACC_MAX;
    else if (acc < longint'(tcpid_pkg::ACC_MIN)) acc = tcpid_pkg::ACC_MIN;
    sum = 2 * longint'(kp) * e + acc + 2 * longint'(kd) * (e - e1);
    y   = sum / 8192;
    err_hist[idx]  = tcpid_pkg::ERR_W'(e);
    integ_acc[idx] = tcpid_pkg::ACC_W'(acc);
    r.clamped = 1'b1;
    if (y < longint'(lim_lo)) y = lim_lo;
    else if (y > longint'(lim_hi)) y = lim_hi;
    else r.clamped = 1'b0;
    r.chan_out = s.chan;
    r.drive    = tcpid_pkg::OUT_W'(y);
    return r;
  endfunction

  task automatic flag_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Check results and record accepted requests at the rising edge
  always @(posedge clk_i) begin : edge_sample
    tcpid_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        drives_seen++;
        out_taken = 1'b1;
        if (drive_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, got %p", $time, out_data);
        end else begin
          want = drive_q.pop_front();
          if (want.clamped) clamp_count++;
          flag_field("chan_out", want.chan_out, out_data.chan_out);
          flag_field("drive", want.drive, out_data.drive);
          flag_field("clamped", want.clamped, out_data.clamped);
        end
      end
      if (in_valid && !in_stall) begin
        drive_q.push_back(compute_drive(in_data));
        samples_taken++;
        in_taken = 1'b1;
      end
    end
  end

  // Sender: hold a stalled request, then idle for the next request's gap
  always @(negedge clk_i) begin : sample_driver
    logic                nv;
    tcpid_pkg::in_item_t nd;
    sample_req_t         r;
    nv = in_valid;
    nd = in_data;
    if (in_taken) begin
      in_taken = 1'b0;
      nv = 1'b0;
      if (sample_q.size() > 0) tx_wait = sample_q[0].gap;
    end
    if (rst_ni && !nv && sample_q.size() > 0) begin
      if (tx_wait > 0) begin
        tx_wait--;
      end else begin
        r  = sample_q.pop_front();
        nd = r.item;
        nv = 1'b1;
      end
    end
    in_valid <= nv;
    in_data  <= nd;
  end

  always @(negedge clk_i) begin : drive_receiver
    if (out_taken) begin
      out_taken = 1'b0;
      rx_wait = $urandom_range(0, idle_max);
    end
    out_stall <= (rx_hold_left > 0) || (rx_wait > 0);
    if (rx_wait > 0) rx_wait--;
  end

  // Long receiver hold-off, counted down here
  always @(posedge clk_i) begin : hold_counter
    if (rx_hold_left > 0) rx_hold_left--;
  end

  task automatic offer(bit ch, int meas);
    sample_req_t r;
    r.item.chan     = ch;
    r.item.measured = tcpid_pkg::MEAS_W'(meas);
    r.gap           = $urandom_range(0, idle_max);
    sample_q.push_back(r);
  endtask

  task automatic offer_random(int n);
    bit ch;
    int base;
    int meas;
    repeat (n) begin
      ch   = $urandom_range(0, 1);
      base = ch ? sp_ch1 : sp_ch0;
      if (base < 0) base = 0;
      case ($urandom_range(0, 9))
        0:          meas = 0;
        1:          meas = MEAS_MAX;
        2, 3, 4, 5: meas = base + rnd(-200, 200);
        default:    meas = $urandom_range(0, MEAS_MAX);
      endcase
      if (meas < 0) meas = 0;
      else if (meas > MEAS_MAX) meas = MEAS_MAX;
      offer(ch, meas);
    end
  endtask

  // Wait until every queued request has gone in and every drive value came out;
  // look at the rising edge, where the sender's outputs are settled
  task automatic settle();
    while (!(sample_q.size() == 0 && !in_valid && drive_q.size() == 0)) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [tcpid_pkg::ADDR_W-1:0] addr,
                           logic [tcpid_pkg::DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(tcpid_pkg::reg_idx_e idx, int val);
    apb_write(tcpid_pkg::ADDR_W'({idx, 2'b00}), tcpid_pkg::DATA_W'(val));
    case (idx)
      tcpid_pkg::REG_GAIN_PROP:  kp     = tcpid_pkg::GAIN_W'(val);
      tcpid_pkg::REG_GAIN_INTEG: ki     = tcpid_pkg::GAIN_W'(val);
      tcpid_pkg::REG_GAIN_DERIV: kd     = tcpid_pkg::GAIN_W'(val);
      tcpid_pkg::REG_OUT_UPPER:  lim_hi = tcpid_pkg::OUT_W'(val);
      tcpid_pkg::REG_OUT_LOWER:  lim_lo = tcpid_pkg::OUT_W'(val);
      tcpid_pkg::REG_TARGET_CH0: sp_ch0 = tcpid_pkg::SP_W'(val);
      tcpid_pkg::REG_TARGET_CH1: sp_ch1 = tcpid_pkg::SP_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_all(int p, int i, int d, int hi, int lo, int s0, int s1);
    settle();
    write_reg(tcpid_pkg::REG_GAIN_PROP, p);
    write_reg(tcpid_pkg::REG_GAIN_INTEG, i);
    write_reg(tcpid_pkg::REG_GAIN_DERIV, d);
    write_reg(tcpid_pkg::REG_OUT_UPPER, hi);
    write_reg(tcpid_pkg::REG_OUT_LOWER, lo);
    write_reg(tcpid_pkg::REG_TARGET_CH0, s0);
    write_reg(tcpid_pkg::REG_TARGET_CH1, s1);
  endtask

  initial begin : stimulus
    int p;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: truncation of a negative sum toward zero
    offer(0, 0);
    offer(0, MEAS_MAX);
    offer(1, MEAS_MAX);
    offer(1, 0);

    // Extreme gains, widest limits, extreme setpoints
    set_all(32767, -32768, -32768, 32767, -32768, 4095, -4096);
    offer(0, 0);
    offer(0, MEAS_MAX);
    offer(1, 0);
    offer(1, MEAS_MAX);
    offer(0, 12'hAAA);
    offer(1, 12'h555);

    // Crossed limits: the lower one wins below it, the upper one elsewhere
    set_all(4096, 0, 0, -100, 100, 0, 2000);
    offer(0, 0);
    offer(0, MEAS_MAX);
    offer(1, 2000);
    offer(1, 1000);

    // Unmapped register index must leave every setting alone
    settle();
    apb_write(tcpid_pkg::ADDR_W'(UNMAPPED_IDX * 4), $urandom());
    offer(0, 5);
    offer(1, 3000);

    // Tiny gains: all three gains set to one, with extreme setpoints
    set_all(1, 1, 1, 32767, -32768, -4096, 4095);
    offer(0, 1);
    offer(1, 1);
    offer(1, 4094);

    for (p = 0; p < 6; p++) begin
      case (p)
        0, 1: set_all(rnd(-8192, 8191), rnd(-64, 64), rnd(-2048, 2047), rnd(1000, 32767),
                      rnd(-32768, -1000), rnd(-4096, 4095), rnd(-4096, 4095));
        2:    set_all(rnd(-8192, 8191), rnd(-16, 16), rnd(-512, 511), rnd(-400, 0),
                      rnd(1, 400), rnd(-4096, 4095), rnd(-4096, 4095));
        3:    set_all(rnd(-32768, 32767), rnd(-1024, 1023), rnd(-32768, 32767),
                      rnd(-32768, 32767), rnd(-32768, 32767), rnd(-4096, 4095),
                      rnd(-4096, 4095));
        4:    set_all(rnd(-32768, 32767), rnd(-32768, 32767), rnd(-32768, 32767),
                      rnd(-32768, 32767), rnd(-32768, 32767), rnd(-4096, 4095),
                      rnd(-4096, 4095));
        default: set_all(pick_end(-32768, 32767), pick_end(-32768, 32767),
                         pick_end(-32768, 32767), pick_end(-32768, 32767),
                         pick_end(-32768, 32767), pick_end(-4096, 4095),
                         pick_end(-4096, 4095));
      endcase
      if (p == 0) begin
        // Block the output long enough to back up the pipeline
        idle_max = 0;
        rx_hold_left = 80;
        offer_random(40);
        idle_max = 6;
        offer_random(85);
      end else begin
        idle_max = (p == 3) ? 0 : 6;
        offer_random(125);
        settle();
        idle_max = 6;
      end
    end

    // Integral wind-up: drive channel zero hard upward,
    // then channel one hard downward, back to back
    settle();
    idle_max = 0;
    set_all(0, -32768, 0, 32767, -32768, -4096, -4096);
    repeat (SOAK_ITEMS) offer(0, MEAS_MAX);
    settle();
    write_reg(tcpid_pkg::REG_GAIN_INTEG, 32767);
    repeat (SOAK_ITEMS) offer(1, MEAS_MAX);
    settle();
    idle_max = 6;
    offer_random(10);

    settle();
    repeat (tcpid_pkg::PIPE_DEPTH + 4) @(negedge clk_i);
    $display("Checked %0d drive values against %0d samples, %0d of them limited.",
             drives_seen, samples_taken, clamp_count);
    $display("Covered directed extremes, crossed limits, random gains and integral wind-up.");
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
